// File: rtl/core/tcpu_pkg.sv
package tcpu_pkg;

    localparam int REG_COUNT_DEF = 16;
    localparam int MEM_BYTES_DEF = 256;

    localparam int DATA_W   = 8;
    localparam int ACTION_W = 3;
    localparam int REG_W    = 4;
    localparam int ADDR_W   = 8;

    // s_tdata: action, reg_sel, second_reg, address, immediate, padded to 32 bits
    localparam int S_FIELDS_W = ACTION_W + 2 * REG_W + ADDR_W + DATA_W;
    localparam int S_TDATA_W  = 32;

    // m_tdata: screen_valid, screen_value, jump_taken, jump_target, padded to 24 bits
    localparam int M_FIELDS_W = 1 + DATA_W + 1 + ADDR_W;
    localparam int M_TDATA_W  = 24;

    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_LOAD_MEM = 3'd0;
    localparam action_t ACT_LOAD_IMM = 3'd1;
    localparam action_t ACT_STORE    = 3'd2;
    localparam action_t ACT_SCREEN   = 3'd3;
    localparam action_t ACT_MOVE     = 3'd4;
    localparam action_t ACT_JUMP_EQ  = 3'd5;
    localparam action_t ACT_JUMP_GT  = 3'd6;

    typedef struct packed {
        logic [ADDR_W-1:0] jump_target;
        logic              jump_taken;
        logic [DATA_W-1:0] screen_value;
        logic              screen_valid;
    } result_t;

endpackage

// File: rtl/core/teaching_cpu_load_store_branch_unit_top.sv
// Execute unit of a small 8-bit teaching machine.
// Slave channel (s_tvalid/s_tready/s_tdata) takes one decoded instruction per
// item: load from memory, load immediate, store, screen, move, jump if equal
// to R0, jump if signed greater than R0. Master channel (m_tvalid/m_tready/
// m_tdata) returns exactly one result item per instruction, in order.
// The result passes through the execute stage and the output register.
// Throughput: one item per cycle while results are taken. Memory is a
// synchronous RAM read when the item is accepted, ahead of execution;
// register file reads/writes and memory writes all happen in the execute
// stage, and a store in execute is forwarded to a load whose RAM read is
// issued in the same cycle, so back-to-back dependencies cost nothing.
// Reset (aresetn low, synchronous) empties the pipeline, clears the register
// file and clears one valid bit per memory byte, so every byte reads as zero
// at once; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register; one more
// item may enter execute behind it, after which s_tready drops until the
// output is taken. No item is lost or repeated.
module teaching_cpu_load_store_branch_unit_top #(
    parameter int REG_COUNT = tcpu_pkg::REG_COUNT_DEF,
    parameter int MEM_BYTES = tcpu_pkg::MEM_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // action[2:0], reg_sel[6:3], second_reg[10:7], address[18:11], immediate[26:19]
    input  logic [tcpu_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // screen_valid[0], screen_value[8:1], jump_taken[9], jump_target[17:10]
    output logic [tcpu_pkg::M_TDATA_W-1:0] m_tdata
);
    import tcpu_pkg::*;

    localparam int RIDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int MIDX_W = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

    // wrap an index past the array size through a table of constants
    function automatic logic [RIDX_W-1:0] wrap_reg(input logic [REG_W-1:0] v);
        logic [RIDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < (1 << REG_W); i++) begin
            if (v == REG_W'(i)) begin
                idx = RIDX_W'(i % REG_COUNT);
            end
        end
        return idx;
    endfunction

    function automatic logic [MIDX_W-1:0] wrap_addr(input logic [ADDR_W-1:0] v);
        logic [MIDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < (1 << ADDR_W); i++) begin
            if (v == ADDR_W'(i)) begin
                idx = MIDX_W'(i % MEM_BYTES);
            end
        end
        return idx;
    endfunction

    // input fields
    action_t           in_action;
    logic [REG_W-1:0]  in_reg;
    logic [REG_W-1:0]  in_reg2;
    logic [ADDR_W-1:0] in_addr;
    logic [DATA_W-1:0] in_imm;
    logic [RIDX_W-1:0] in_r;
    logic [RIDX_W-1:0] in_r2;
    logic [MIDX_W-1:0] in_ma;

    assign in_action = s_tdata[ACTION_W-1:0];
    assign in_reg    = s_tdata[ACTION_W +: REG_W];
    assign in_reg2   = s_tdata[ACTION_W+REG_W +: REG_W];
    assign in_addr   = s_tdata[ACTION_W+2*REG_W +: ADDR_W];
    assign in_imm    = s_tdata[ACTION_W+2*REG_W+ADDR_W +: DATA_W];
    assign in_r      = wrap_reg(in_reg);
    assign in_r2     = wrap_reg(in_reg2);
    assign in_ma     = wrap_addr(in_addr);

    // state
    logic [DATA_W-1:0]    rf_reg [REG_COUNT];
    logic [DATA_W-1:0]    mem_ram [MEM_BYTES];
    logic [MEM_BYTES-1:0] mem_vld_reg;

    // execute stage
    logic              s1_valid_reg;
    action_t           s1_action_reg;
    logic [RIDX_W-1:0] s1_r_reg;
    logic [RIDX_W-1:0] s1_r2_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [MIDX_W-1:0] s1_ma_reg;
    logic [DATA_W-1:0] s1_imm_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic              fwd_reg;
    logic [DATA_W-1:0] fwd_data_reg;

    // output stage
    logic    m_valid_reg;
    result_t res_reg;
    result_t res_next;

    logic              s_fire;
    logic              s1_fire;
    logic [DATA_W-1:0] src_val;
    logic [DATA_W-1:0] r0_val;
    logic [DATA_W-1:0] load_val;
    logic              cond;

    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_fire   = s_tvalid && s_tready;

    assign src_val  = rf_reg[s1_r_reg];
    assign r0_val   = rf_reg[0];
    assign load_val = fwd_reg ? fwd_data_reg : (rd_vld_reg ? rd_data_reg : '0);

    always_comb begin
        cond     = 1'b0;
        res_next = '0;
        case (s1_action_reg)
            ACT_SCREEN: begin
                res_next.screen_valid = 1'b1;
                res_next.screen_value = src_val;
            end
            ACT_JUMP_EQ: cond = (src_val == r0_val);
            ACT_JUMP_GT: cond = ($signed(src_val) > $signed(r0_val));
            default: ;
        endcase
        if (cond) begin
            res_next.jump_taken  = 1'b1;
            res_next.jump_target = s1_addr_reg;
        end
    end

    // RAM: read issued at accept, written from the execute stage
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_data_reg  <= mem_ram[in_ma];
            // hold the byte being stored this cycle if the addresses match
            fwd_reg      <= s1_fire && (s1_action_reg == ACT_STORE) && (s1_ma_reg == in_ma);
            fwd_data_reg <= src_val;
        end
        if (s1_fire && (s1_action_reg == ACT_STORE)) begin
            mem_ram[s1_ma_reg] <= src_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                rd_vld_reg <= mem_vld_reg[in_ma];
            end
            if (s1_fire && (s1_action_reg == ACT_STORE)) begin
                mem_vld_reg[s1_ma_reg] <= 1'b1;
            end
        end
    end

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                rf_reg[i] <= '0;
            end
        end else if (s1_fire) begin
            case (s1_action_reg)
                ACT_LOAD_MEM: rf_reg[s1_r_reg]  <= load_val;
                ACT_LOAD_IMM: rf_reg[s1_r_reg]  <= s1_imm_reg;
                ACT_MOVE:     rf_reg[s1_r2_reg] <= src_val;
                default: ;
            endcase
        end
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_action_reg <= in_action;
            s1_r_reg      <= in_r;
            s1_r2_reg     <= in_r2;
            s1_addr_reg   <= in_addr;
            s1_ma_reg     <= in_ma;
            s1_imm_reg    <= in_imm;
        end
        if (s1_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, res_reg};

    // unused padding bits of s_tdata
    logic unused_pad;
    assign unused_pad = ^s_tdata[S_TDATA_W-1:S_FIELDS_W];

endmodule
